### rtl/core/fssc_pkg.sv
// Package for the frame session stamp CRC block.
// Word types, header and command constants, and the byte-wide CRC-16 step.
// No dependencies.
`default_nettype none

package fssc_pkg;

  // Frame layout
  localparam logic [7:0]  HdrByte0   = 8'hCA;
  localparam logic [7:0]  HdrByte1   = 8'hFD;
  localparam logic [8:0]  HdrLen     = 9'd7;
  localparam logic [8:0]  SessionAt  = 9'd11;
  localparam logic [8:0]  SessionEnd = 9'd14;
  localparam logic [7:0]  MinPayload = 8'd16;
  localparam logic [8:0]  PosMax     = 9'd511;

  // Command identifiers
  localparam logic [31:0] CmdId0 = 32'h0000_0080;
  localparam logic [31:0] CmdId1 = 32'h0000_0091;
  localparam logic [31:0] CmdId2 = 32'h0000_0101;
  localparam logic [31:0] CmdId3 = 32'h0000_0111;
  localparam logic [31:0] CmdId4 = 32'h0000_0121;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [31:0] SessionReset = 32'h0000_0001;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic        updated;
    logic [15:0] crc_value;
    logic [8:0]  crc_position;
  } out_word_t;

  // One byte through the CRC, MSB first, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic is_command(input logic [31:0] id);
    return (id == CmdId0) || (id == CmdId1) || (id == CmdId2) ||
           (id == CmdId3) || (id == CmdId4);
  endfunction

endpackage

`default_nettype wire

### rtl/core/fssc_in_stage.sv
// Input register of the frame session stamp CRC block.
// Holds one accepted word until the frame logic takes it; uses fssc_pkg.
`default_nettype none

module fssc_in_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  fssc_pkg::in_word_t  in_word_i,
  input  wire                 out_free_i,
  output logic                move_o,
  output fssc_pkg::in_word_t  word_o
);

  logic               valid_q, valid_d;
  fssc_pkg::in_word_t word_q;
  logic               load;

  // A non-final byte always moves on; the final one needs a free result slot
  assign move_o     = valid_q && (!word_q.frame_end || out_free_i);
  assign in_stall_o = valid_q && !move_o;
  assign load       = in_valid_i && !in_stall_o;
  assign word_o     = word_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (move_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fssc_frame.sv
// Per-frame state and verdict logic of the frame session stamp CRC block.
// Header check, identifier, length, running CRC with session stamping; uses fssc_pkg.
`default_nettype none

module fssc_frame (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 move_i,
  input  fssc_pkg::in_word_t  word_i,
  input  wire  [31:0]         session_i,
  output fssc_pkg::out_word_t res_o
);

  logic [8:0]  pos_q, pos_d;
  logic        hdr_q, hdr_d;
  logic [31:0] ident_q, ident_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;

  logic        in_crc;
  logic        in_session;
  logic [1:0]  sess_sel;
  logic [7:0]  crc_in_byte;
  logic        ok;

  // Payload bytes 7 .. P+4 are covered; bytes 11..14 come from the session word
  assign in_crc     = (pos_q >= fssc_pkg::HdrLen) &&
                      ({1'b0, pos_q} <= ({2'b00, len_q} + 10'd4));
  assign in_session = (pos_q >= fssc_pkg::SessionAt) && (pos_q <= fssc_pkg::SessionEnd);
  // (pos - 11) mod 4 equals pos + 1 mod 4
  assign sess_sel   = pos_q[1:0] + 2'd1;

  always_comb begin
    case (sess_sel)
      2'd0:    crc_in_byte = session_i[7:0];
      2'd1:    crc_in_byte = session_i[15:8];
      2'd2:    crc_in_byte = session_i[23:16];
      default: crc_in_byte = session_i[31:24];
    endcase
    if (!in_session) begin
      crc_in_byte = word_i.data_byte;
    end
  end

  // State update for the byte at hand
  always_comb begin
    hdr_d   = hdr_q;
    ident_d = ident_q;
    len_d   = len_q;
    crc_d   = crc_q;
    if (pos_q == 9'd0 && word_i.data_byte != fssc_pkg::HdrByte0) begin
      hdr_d = 1'b0;
    end
    if (pos_q == 9'd1 && word_i.data_byte != fssc_pkg::HdrByte1) begin
      hdr_d = 1'b0;
    end
    if (pos_q >= 9'd2 && pos_q <= 9'd5) begin
      ident_d = {ident_q[23:0], word_i.data_byte};
    end
    if (pos_q == 9'd6) begin
      len_d = word_i.data_byte;
    end
    if (in_crc) begin
      crc_d = fssc_pkg::crc16_byte(crc_q, crc_in_byte);
    end
    pos_d = pos_q;
    if (pos_q != fssc_pkg::PosMax) begin
      pos_d = pos_q + 9'd1;
    end
  end

  // Verdict, valid only on the final byte
  assign ok = (pos_q >= 9'd6) && hdr_d && fssc_pkg::is_command(ident_d) &&
              (len_d >= fssc_pkg::MinPayload) &&
              ({1'b0, pos_q} == (10'd6 + {2'b00, len_d}));

  always_comb begin
    res_o.updated      = ok;
    res_o.crc_value    = ok ? crc_d : 16'h0000;
    res_o.crc_position = ok ? ({1'b0, len_d} + 9'd5) : 9'd0;
  end

  // Frame state; cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 9'd0;
      hdr_q   <= 1'b1;
      ident_q <= 32'd0;
      len_q   <= 8'd0;
      crc_q   <= fssc_pkg::CrcInit;
    end else if (move_i) begin
      if (word_i.frame_end) begin
        pos_q   <= 9'd0;
        hdr_q   <= 1'b1;
        ident_q <= 32'd0;
        len_q   <= 8'd0;
        crc_q   <= fssc_pkg::CrcInit;
      end else begin
        pos_q   <= pos_d;
        hdr_q   <= hdr_d;
        ident_q <= ident_d;
        len_q   <= len_d;
        crc_q   <= crc_d;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/fssc_out_stage.sv
// Result register of the frame session stamp CRC block.
// Holds one verdict word until the receiver takes it; uses fssc_pkg.
`default_nettype none

module fssc_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  fssc_pkg::out_word_t  res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output fssc_pkg::out_word_t  out_word_o
);

  logic                valid_q, valid_d;
  fssc_pkg::out_word_t word_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= res_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/frame_session_stamp_crc.sv
// Frame session stamp CRC: top level. Instantiates fssc_in_stage, fssc_frame,
// fssc_out_stage and the session register; uses fssc_pkg.
//
// Takes one frame byte per cycle (frame_end on the last byte) and gives one
// verdict word per frame: updated, the CRC-16/CCITT-FALSE over the payload
// without its last two bytes with the session word stamped into bytes 11..14
// (LSB first), and the CRC low-byte offset. One byte per cycle sustained if
// no verdict waits on a final byte: the byte-wide CRC step sits between the
// input register and the frame state. The verdict is loaded into the result
// register as the final byte leaves the input register; a waiting verdict
// stalls only the next frame's final byte. No clearing pass after reset.
`default_nettype none

module frame_session_stamp_crc (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  fssc_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output fssc_pkg::out_word_t  out_word_o,
  input  wire                  cfg_we_i,
  input  wire  [31:0]          cfg_wdata_i
);

  logic                verdict_load;
  logic [31:0]         session_word_q;
  logic                out_free;
  logic                move;
  fssc_pkg::in_word_t  s1_word;
  fssc_pkg::out_word_t res;

  // Session register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_word_q <= fssc_pkg::SessionReset;
    end else if (cfg_we_i) begin
      session_word_q <= cfg_wdata_i;
    end
  end

  fssc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_free_i (out_free),
    .move_o     (move),
    .word_o     (s1_word)
  );

  fssc_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .move_i    (move),
    .word_i    (s1_word),
    .session_i (session_word_q),
    .res_o     (res)
  );

  // A verdict is loaded when the final byte leaves the input register
  assign verdict_load = move && s1_word.frame_end;

  fssc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (verdict_load),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

### rtl/core/fssc_checker.sv
// Port-level checks for the frame session stamp CRC block.
// Bound to frame_session_stamp_crc; uses fssc_pkg.
`default_nettype none

module fssc_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input fssc_pkg::out_word_t out_word_o
);

  // A held verdict stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("verdict dropped while stalled");

  // Input side stalls only behind a waiting verdict
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting verdict");

  // Rejected frames carry zero CRC and offset
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.updated |->
      out_word_o.crc_value == 16'h0000 && out_word_o.crc_position == 9'd0)
    else $error("rejected frame carries CRC fields");

  // Accepted frames have payload of 16..255 bytes, so offset 21..260
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.updated |->
      out_word_o.crc_position >= 9'd21 && out_word_o.crc_position <= 9'd260)
    else $error("CRC offset out of range");

endmodule

bind frame_session_stamp_crc fssc_checker u_fssc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
